// ===== rtl/core/ima_pkg.sv =====
// Package for the interval map table: sizes, codes, cell control word.
// Used by the channel interfaces, ima_cell and interval_map_table_core.
package ima_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 8;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int TW          = CNT_W + 1;

  localparam logic [VALUE_WIDTH-1:0] RESET_VALUE = VALUE_WIDTH'(97);

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam int REG_INITIAL_VALUE = 0;

  typedef logic [KEY_WIDTH-1:0]   key_t;
  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INIT,
    CMD_CMP,
    CMD_SHR,
    CMD_SHL,
    CMD_INS
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t         cmd;
    key_t              lo;
    key_t              ck;
    logic [TW-1:0]     t;
    logic [TW-1:0]     a;
    logic              one_ins;
    logic              two_ins;
    key_t              ins0_key;
    val_t              ins0_val;
    key_t              ins1_key;
    val_t              ins1_val;
    val_t              initv;
  } cell_ctl_t;

endpackage

// ===== rtl/core/ima_if.sv =====
// Valid/ready channel interfaces for the interval map table.
// Depend on ima_pkg for field widths.
interface ima_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   operation;
  logic signed [ima_pkg::KEY_WIDTH-1:0]   key_low;
  logic signed [ima_pkg::KEY_WIDTH-1:0]   key_high;
  logic [ima_pkg::VALUE_WIDTH-1:0]        new_value;
  modport source (output valid, operation, key_low, key_high, new_value, input ready);
  modport sink   (input valid, operation, key_low, key_high, new_value, output ready);
endinterface

interface ima_out_if;
  logic                              valid;
  logic                              ready;
  logic [ima_pkg::VALUE_WIDTH-1:0]   found_value;
  logic [1:0]                        status;
  modport source (output valid, found_value, status, input ready);
  modport sink   (input valid, found_value, status, output ready);
endinterface

// ===== rtl/core/interval_map_table_core.sv =====
// Interval map table: chain of breakpoint cells plus sequencing control.
// Throughput: one word at a time; the next word can be accepted from the cycle
// after the result is queued. An applied assign shifts the tail one cell per cycle.
// Reset (synchronous, rst_n low): one entry at the minimum key holding 97.
// Writing initial_value reinitializes the table.
module interval_map_table_core (
  input  logic        clk,
  input  logic        rst_n,
  ima_in_if.sink      in_ch,
  ima_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CAP = ima_pkg::CAPACITY;
  localparam int CW  = ima_pkg::CNT_W;
  localparam int TW  = ima_pkg::TW;

  typedef enum logic [2:0] {S_IDLE, S_CMP, S_SEL, S_SHIFT, S_INS, S_RES} state_t;

  state_t state_r;
  ima_pkg::val_t initv_r;
  logic [CW-1:0] count_r;
  logic [TW-1:0] newcnt_r, t_r, a_r, tgt_r;
  logic          op_r;
  ima_pkg::key_t lo_r, hi_r;
  ima_pkg::val_t nv_r;
  logic          one_r, two_r;
  ima_pkg::key_t i0k_r, i1k_r;
  ima_pkg::val_t i0v_r, i1v_r;
  ima_pkg::val_t res_val_r;
  logic [1:0]    res_st_r;
  logic          out_valid_r;
  ima_pkg::val_t out_val_r;
  logic [1:0]    out_st_r;

  ima_pkg::cell_ctl_t ctl;
  ima_pkg::key_t key_w [CAP];
  ima_pkg::val_t val_w [CAP];
  logic [CAP-1:0] lt_w, le_w;

  logic cfg_wr;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 3'(4 * ima_pkg::REG_INITIAL_VALUE)) ?
                      32'(initv_r) : 32'd0;

  // chain of cells
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    ima_pkg::key_t lk, rk;
    ima_pkg::val_t lv, rv;
    if (i == 0) begin : g_l0
      assign lk = key_w[0];
      assign lv = val_w[0];
    end else begin : g_l
      assign lk = key_w[i-1];
      assign lv = val_w[i-1];
    end
    if (i == CAP - 1) begin : g_rt
      assign rk = '0;
      assign rv = '0;
    end else begin : g_r
      assign rk = key_w[i+1];
      assign rv = val_w[i+1];
    end
    ima_cell u_cell (
      .clk(clk), .rst_n(rst_n), .idx(CW'(i)), .valid(CW'(i) < count_r), .ctl(ctl),
      .left_key(lk), .left_val(lv), .right_key(rk), .right_val(rv),
      .key_o(key_w[i]), .val_o(val_w[i]), .lt_o(lt_w[i]), .le_o(le_w[i])
    );
  end

  // boundary selection over the registered compare flags
  ima_pkg::val_t before_v, after_v, first_v, last1_v, last_v;
  logic [TW-1:0] a_enc, b_enc, bp, tgt, newcnt;
  logic          first_ex, ins_lo, ins_hi, drop, ignore;
  logic [1:0]    k;

  always_comb begin
    before_v = '0;
    after_v  = '0;
    first_v  = '0;
    a_enc    = '0;
    b_enc    = '0;
    first_ex = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      logic nlt, nle, f;
      nlt = (i == CAP - 1) ? 1'b0 : lt_w[(i == CAP - 1) ? i : i + 1];
      nle = (i == CAP - 1) ? 1'b0 : le_w[(i == CAP - 1) ? i : i + 1];
      f   = (i != 0) && le_w[(i == 0) ? 0 : i - 1] && !le_w[i] && (CW'(i) < count_r);
      if (lt_w[i] && !nlt) begin
        before_v = before_v | val_w[i];
        a_enc    = a_enc | TW'(i + 1);
      end
      if (le_w[i] && !nle) begin
        after_v = after_v | val_w[i];
        b_enc   = b_enc | TW'(i + 1);
      end
      if (f) begin
        first_v  = first_v | val_w[i];
        first_ex = 1'b1;
      end
    end
    ins_lo  = (nv_r != before_v);
    last1_v = ins_lo ? nv_r : before_v;
    ins_hi  = (after_v != last1_v);
    last_v  = ins_hi ? after_v : last1_v;
    k       = 2'(ins_lo) + 2'(ins_hi);
    drop    = first_ex && (first_v == last_v);
    bp      = b_enc + TW'(drop);
    tgt     = a_enc + TW'(k);
    newcnt  = tgt + TW'(count_r) - bp;
    ignore  = (lo_r >= hi_r) || (lo_r == '0) || (hi_r == '0);
  end

  // cell command
  always_comb begin
    ctl          = '0;
    ctl.cmd      = ima_pkg::CMD_HOLD;
    ctl.lo       = lo_r;
    ctl.ck       = (op_r == ima_pkg::OP_LOOKUP) ? lo_r : hi_r;
    ctl.t        = t_r;
    ctl.a        = a_r;
    ctl.one_ins  = one_r;
    ctl.two_ins  = two_r;
    ctl.ins0_key = i0k_r;
    ctl.ins0_val = i0v_r;
    ctl.ins1_key = i1k_r;
    ctl.ins1_val = i1v_r;
    ctl.initv    = ima_pkg::val_t'(cfg_pwdata);
    if (cfg_wr && cfg_paddr == 3'(4 * ima_pkg::REG_INITIAL_VALUE)) begin
      ctl.cmd = ima_pkg::CMD_INIT;
    end else begin
      case (state_r)
        S_CMP:   ctl.cmd = ima_pkg::CMD_CMP;
        S_SHIFT: begin
          if (t_r < tgt_r)      ctl.cmd = ima_pkg::CMD_SHR;
          else if (t_r > tgt_r) ctl.cmd = ima_pkg::CMD_SHL;
        end
        S_INS:   ctl.cmd = ima_pkg::CMD_INS;
        default: ctl.cmd = ima_pkg::CMD_HOLD;
      endcase
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      initv_r     <= ima_pkg::RESET_VALUE;
      count_r     <= CW'(1);
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_RES) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r  <= in_ch.operation;
            lo_r  <= in_ch.key_low ^ {1'b1, {(ima_pkg::KEY_WIDTH-1){1'b0}}};
            hi_r  <= in_ch.key_high ^ {1'b1, {(ima_pkg::KEY_WIDTH-1){1'b0}}};
            nv_r  <= in_ch.new_value;
            state_r <= S_CMP;
          end
        end
        S_CMP: state_r <= S_SEL;
        S_SEL: begin
          res_val_r <= '0;
          res_st_r  <= ima_pkg::ST_DONE;
          state_r   <= S_RES;
          if (op_r == ima_pkg::OP_LOOKUP) begin
            res_val_r <= after_v;
          end else if (ignore) begin
            res_st_r <= ima_pkg::ST_IGNORED;
          end else if (newcnt > TW'(CAP)) begin
            res_st_r <= ima_pkg::ST_FULL;
          end else begin
            t_r      <= bp;
            tgt_r    <= tgt;
            a_r      <= a_enc;
            newcnt_r <= newcnt;
            one_r    <= (k != 2'd0);
            two_r    <= (k == 2'd2);
            i0k_r    <= ins_lo ? lo_r : hi_r;
            i0v_r    <= ins_lo ? nv_r : after_v;
            i1k_r    <= hi_r;
            i1v_r    <= after_v;
            state_r  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (t_r < tgt_r)      t_r <= t_r + TW'(1);
          else if (t_r > tgt_r) t_r <= t_r - TW'(1);
          else                  state_r <= S_INS;
        end
        S_INS: begin
          count_r <= CW'(newcnt_r);
          state_r <= S_RES;
        end
        S_RES: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_val_r   <= res_val_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      if (cfg_wr && cfg_paddr == 3'(4 * ima_pkg::REG_INITIAL_VALUE)) begin
        initv_r <= ima_pkg::val_t'(cfg_pwdata);
        count_r <= CW'(1);
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found_value = out_val_r;
  assign out_ch.status      = out_st_r;

endmodule

// ===== rtl/core/ima_cell.sv =====
// One breakpoint cell of the table chain: key, value and compare flags.
// Depends on ima_pkg; neighbors feed it on shifts.
module ima_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ima_pkg::CNT_W-1:0] idx,
  input  logic                      valid,
  input  ima_pkg::cell_ctl_t        ctl,
  input  ima_pkg::key_t             left_key,
  input  ima_pkg::val_t             left_val,
  input  ima_pkg::key_t             right_key,
  input  ima_pkg::val_t             right_val,
  output ima_pkg::key_t             key_o,
  output ima_pkg::val_t             val_o,
  output logic                      lt_o,
  output logic                      le_o
);

  ima_pkg::key_t key_r, key_nxt;
  ima_pkg::val_t val_r, val_nxt;
  logic          lt_r, lt_nxt, le_r, le_nxt;
  logic [ima_pkg::TW-1:0] pos;

  assign pos = ima_pkg::TW'(idx);

  always_comb begin
    key_nxt = key_r;
    val_nxt = val_r;
    lt_nxt  = lt_r;
    le_nxt  = le_r;
    case (ctl.cmd)
      ima_pkg::CMD_INIT: begin
        key_nxt = '0;
        val_nxt = ctl.initv;
      end
      ima_pkg::CMD_CMP: begin
        lt_nxt = valid && (key_r < ctl.lo);
        le_nxt = valid && (key_r <= ctl.ck);
      end
      ima_pkg::CMD_SHR: begin
        if (pos > ctl.t) begin
          key_nxt = left_key;
          val_nxt = left_val;
        end
      end
      ima_pkg::CMD_SHL: begin
        // t is at least one here
        if (pos + ima_pkg::TW'(1) >= ctl.t) begin
          key_nxt = right_key;
          val_nxt = right_val;
        end
      end
      ima_pkg::CMD_INS: begin
        if (ctl.one_ins && pos == ctl.a) begin
          key_nxt = ctl.ins0_key;
          val_nxt = ctl.ins0_val;
        end else if (ctl.two_ins && pos == ctl.a + ima_pkg::TW'(1)) begin
          key_nxt = ctl.ins1_key;
          val_nxt = ctl.ins1_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      val_r <= ima_pkg::RESET_VALUE;
      lt_r  <= 1'b0;
      le_r  <= 1'b0;
    end else begin
      key_r <= key_nxt;
      val_r <= val_nxt;
      lt_r  <= lt_nxt;
      le_r  <= le_nxt;
    end
  end

  assign key_o = key_r;
  assign val_o = val_r;
  assign lt_o  = lt_r;
  assign le_o  = le_r;

endmodule
